@@ sv/uida_pkg.sv @@
// Types and codes shared by the unique identifier allocator.
// No dependencies; imported by uida_free_stack and unique_id_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

package uida_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;

  localparam logic REG_ID_LOW  = 1'b0;
  localparam logic REG_ID_HIGH = 1'b1;

  localparam logic [15:0] ID_LOW_RST  = 16'd0;
  localparam logic [15:0] ID_HIGH_RST = 16'd1023;

  typedef struct packed {
    logic        command;
    logic [15:0] release_id;
  } req_t;

  typedef struct packed {
    logic [15:0] granted_id;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_sts_t;

endpackage

`default_nettype wire

@@ sv/uida_free_stack.sv @@
// LIFO of freed identifiers: top and next-below entry in registers, rest in RAM.
// Depends on uida_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uida_free_stack #(
  parameter int MAX_IDS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  uida_pkg::stack_ctl_t   ctl,
  input  logic [15:0]            push_id,
  output logic [15:0]            top_id,
  output uida_pkg::stack_sts_t   sts
);
  import uida_pkg::*;

  localparam int AW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [15:0]   below;
  logic [15:0]   mem [MAX_IDS];
  logic          do_push;
  logic          do_pop;

  assign do_push   = ctl.push && (count != CW'(MAX_IDS));
  assign do_pop    = ctl.pop && (count != '0);
  assign sts.empty = (count == '0);
  assign sts.full  = (count == CW'(MAX_IDS));

  always_comb begin
    count_next = count;
    if (ctl.clr) begin
      count_next = '0;
    end else if (do_push) begin
      count_next = count + CW'(1);
    end else if (do_pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_id <= push_id;
    end else if (do_pop) begin
      top_id <= below;
    end
  end

  // old top spills to RAM on push; entry below the new top is fetched on pop
  always_ff @(posedge clk) begin
    if (do_push && (count != '0)) begin
      mem[AW'(count - CW'(1))] <= top_id;
    end
    if (do_push) begin
      below <= top_id;
    end else if (do_pop) begin
      below <= mem[AW'(count - CW'(3))];
    end
  end

endmodule

`default_nettype wire

@@ sv/unique_id_allocator_unit.sv @@
// Unique identifier allocator: free stack plus watermark, in-use bitmap in RAM.
// The request is registered in stage 1, then its result in the response register.
// One request per cycle while responses drain; a stalled response holds stage 1,
// after which the request side stalls.
// Reset clears control state only; map bits above the watermark read as clear,
// so no clearing pass. Writing id_low restarts the allocator in the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module unique_id_allocator_unit #(
  parameter int MAX_IDS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  uida_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output uida_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import uida_pkg::*;

  localparam int SW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);

  logic [15:0]   id_low;
  logic [15:0]   id_high;
  logic [CW-1:0] fresh_off;
  logic [CW-1:0] fresh_off_next;

  logic          s1_valid;
  req_t          s1_req;
  logic          s1_bit;
  logic          adv;
  logic          accept;
  logic          cfg_we;

  logic          map_mem [MAX_IDS];
  logic          map_we;
  logic [SW-1:0] map_wa;
  logic          map_wd;
  logic [16:0]   in_diff;
  logic [SW-1:0] rd_slot;

  stack_ctl_t    stk_ctl;
  stack_sts_t    stk_sts;
  logic [15:0]   top_id;
  rsp_t          rsp_next;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;
  assign accept    = req_valid && !req_stall;
  assign in_diff   = {1'b0, req.release_id} - {1'b0, id_low};
  assign rd_slot   = in_diff[SW-1:0];

  uida_free_stack #(
    .MAX_IDS (MAX_IDS)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk_ctl),
    .push_id (s1_req.release_id),
    .top_id  (top_id),
    .sts     (stk_sts)
  );

  // decision for the request held in stage 1
  always_comb begin
    logic [16:0]   fresh_id;
    logic [16:0]   rel_diff;
    logic [15:0]   pop_diff;
    logic [SW-1:0] rel_slot;
    logic          fresh_ok;
    logic          rel_ok;
    logic          in_use;

    fresh_id = {1'b0, id_low} + 17'(fresh_off);
    rel_diff = {1'b0, s1_req.release_id} - {1'b0, id_low};
    pop_diff = top_id - id_low;
    rel_slot = rel_diff[SW-1:0];
    fresh_ok = (fresh_id <= {1'b0, id_high}) && (fresh_off != CW'(MAX_IDS));
    rel_ok   = !rel_diff[16] && (rel_diff < 17'(MAX_IDS));
    in_use   = (CW'(rel_slot) < fresh_off) && s1_bit;

    rsp_next.granted_id = '0;
    rsp_next.status     = ST_OK;
    stk_ctl.clr         = cfg_we && (cfg_index == REG_ID_LOW);
    stk_ctl.push        = 1'b0;
    stk_ctl.pop         = 1'b0;
    map_we              = 1'b0;
    map_wa              = rel_slot;
    map_wd              = 1'b0;
    fresh_off_next      = fresh_off;

    if (s1_req.command == CMD_ALLOC) begin
      if (!stk_sts.empty) begin
        rsp_next.granted_id = top_id;
        stk_ctl.pop         = adv;
        map_we              = adv;
        map_wa              = SW'(pop_diff);
        map_wd              = 1'b1;
      end else if (fresh_ok) begin
        rsp_next.granted_id = fresh_id[15:0];
        map_we              = adv;
        map_wa              = fresh_off[SW-1:0];
        map_wd              = 1'b1;
        fresh_off_next      = fresh_off + CW'(1);
      end else begin
        rsp_next.status = ST_EXHAUSTED;
      end
    end else begin
      if (rel_ok && in_use) begin
        stk_ctl.push = adv;
        map_we       = adv;
      end else begin
        rsp_next.status = ST_BAD_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_low  <= ID_LOW_RST;
      id_high <= ID_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ID_LOW:  id_low  <= cfg_data;
        REG_ID_HIGH: id_high <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_off <= '0;
    end else if (stk_ctl.clr) begin
      fresh_off <= '0;
    end else if (adv) begin
      fresh_off <= fresh_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  // in-use map; a write landing on the slot being read is forwarded
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (accept) begin
      s1_bit <= (map_we && (map_wa == rd_slot)) ? map_wd : map_mem[rd_slot];
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stalled with stage 1 empty");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.granted_id == '0))
    else $error("identifier granted alongside an error status");

  a_restart_on_low: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_ID_LOW))
      |=> ((fresh_off == '0) && stk_sts.empty))
    else $error("allocator not restarted after id_low write");

  a_watermark_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_off <= CW'(MAX_IDS))
    else $error("watermark offset beyond identifier space");

endmodule

`default_nettype wire
